// ===== src/pab_pkg.sv =====
// Package for the packet ALU byte slave: event codes, opcodes, defaults
// and the request and response types between the top level and the
// arithmetic unit. Depends on nothing.
package pab_pkg;

  localparam int OPERAND_BYTES_DEF = 4;
  localparam int OPCODE_BYTES      = 4;
  localparam int RESULT_BITS       = 32;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [31:0] OPC_ADD = 32'd0;
  localparam logic [31:0] OPC_MUL = 32'd1;
  localparam logic [31:0] OPC_DIV = 32'd2;
  localparam logic [31:0] OPC_SUB = 32'd3;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_DIV = 2'd2,
    KIND_SUB = 2'd3
  } kind_t;

  typedef struct packed {
    logic  start;
    kind_t kind;
  } arith_req_t;

  typedef struct packed {
    logic                   done;
    logic [RESULT_BITS-1:0] result;
  } arith_rsp_t;

endpackage

// ===== src/pab_arith.sv =====
// Iterative arithmetic unit of the packet ALU: add, subtract, shift-add
// multiply and restoring divide, all through one shared adder.
// Depends on pab_pkg.
module pab_arith #(
  parameter int OPERAND_BYTES = pab_pkg::OPERAND_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pab_pkg::arith_req_t             req,
  input  logic signed [8*OPERAND_BYTES-1:0] op_a,
  input  logic signed [8*OPERAND_BYTES-1:0] op_b,
  output pab_pkg::arith_rsp_t             rsp
);

  localparam int W    = 8 * OPERAND_BYTES;
  localparam int RB   = pab_pkg::RESULT_BITS;
  localparam int AW   = (W + 1 > RB + 1) ? W + 1 : RB + 1;
  localparam int MAXN = (W > RB) ? W : RB;
  localparam int CW   = $clog2(MAXN + 1);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_MUL  = 5'b00010,
    U_DIV  = 5'b00100,
    U_NEG  = 5'b01000,
    U_DONE = 5'b10000
  } ustate_t;

  ustate_t        state_r;
  logic [RB-1:0]  res_r;
  logic [RB-1:0]  mcand_r;
  logic [RB-1:0]  mplier_r;
  logic [W-1:0]   quo_r;
  logic [W-1:0]   rem_r;
  logic [W-1:0]   div_r;
  logic           neg_r;
  logic [CW-1:0]  cnt_r;

  logic [AW-1:0]  add_x;
  logic [AW-1:0]  add_y;
  logic           add_cin;
  logic [AW:0]    add_sum;
  logic [W:0]     shifted;
  logic           ge;
  logic [W-1:0]   rem_nxt;
  logic [W-1:0]   quo_nxt;
  logic [W-1:0]   a_u;
  logic [W-1:0]   b_u;
  logic [W-1:0]   a_mag;
  logic [W-1:0]   b_mag;
  logic [RB-1:0]  a_32;
  logic [RB-1:0]  b_32;

  always_comb begin
    a_u   = W'(op_a);
    b_u   = W'(op_b);
    a_mag = a_u[W-1] ? (~a_u + W'(1)) : a_u;
    b_mag = b_u[W-1] ? (~b_u + W'(1)) : b_u;
    a_32  = RB'(op_a);
    b_32  = RB'(op_b);
    shifted = {rem_r, quo_r[W-1]};
  end

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state_r)
      U_IDLE: begin
        add_x = AW'(a_32);
        if (req.kind == pab_pkg::KIND_SUB) begin
          add_y   = ~AW'(b_32);
          add_cin = 1'b1;
        end else begin
          add_y = AW'(b_32);
        end
      end
      U_MUL: begin
        add_x = AW'(res_r);
        add_y = mplier_r[0] ? AW'(mcand_r) : '0;
      end
      U_DIV: begin
        add_x   = AW'(shifted);
        add_y   = ~AW'(div_r);
        add_cin = 1'b1;
      end
      U_NEG: begin
        add_y   = ~AW'(res_r);
        add_cin = 1'b1;
      end
      U_DONE: begin
        add_x = '0;
      end
      default: begin
        add_x = '0;
      end
    endcase
    add_sum = (AW + 1)'(add_x) + (AW + 1)'(add_y) + (AW + 1)'(add_cin);
    ge      = add_sum[AW];
    rem_nxt = ge ? add_sum[W-1:0] : shifted[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      unique case (state_r)
        U_IDLE: begin
          if (req.start) begin
            unique case (req.kind) inside
              pab_pkg::KIND_ADD, pab_pkg::KIND_SUB: begin
                res_r   <= add_sum[RB-1:0];
                state_r <= U_DONE;
              end
              pab_pkg::KIND_MUL: begin
                res_r    <= '0;
                mcand_r  <= a_32;
                mplier_r <= b_32;
                cnt_r    <= CW'(RB);
                state_r  <= U_MUL;
              end
              pab_pkg::KIND_DIV: begin
                if (b_u == '0) begin
                  res_r   <= '0;
                  state_r <= U_DONE;
                end else begin
                  quo_r   <= a_mag;
                  div_r   <= b_mag;
                  rem_r   <= '0;
                  neg_r   <= a_u[W-1] ^ b_u[W-1];
                  cnt_r   <= CW'(W);
                  state_r <= U_DIV;
                end
              end
              default: begin
                state_r <= U_IDLE;
              end
            endcase
          end
        end
        U_MUL: begin
          res_r    <= add_sum[RB-1:0];
          mcand_r  <= {mcand_r[RB-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[RB-1:1]};
          cnt_r    <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_r <= U_DONE;
          end
        end
        U_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            res_r   <= RB'(quo_nxt);
            state_r <= neg_r ? U_NEG : U_DONE;
          end
        end
        U_NEG: begin
          res_r   <= add_sum[RB-1:0];
          state_r <= U_DONE;
        end
        U_DONE: begin
          state_r <= U_IDLE;
        end
        default: begin
          state_r <= U_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = (state_r == U_DONE);
  assign rsp.result = res_r;

endmodule

// ===== src/packet_alu_byte_slave_core.sv =====
// Top level of the packet ALU byte slave: event decoding, packet store,
// result word and read-back. Depends on pab_pkg and pab_arith.
//
// One item is one bus event on in_func (start, stop, written byte or read
// request) with in_wdata. An item is taken at a clock edge where start is
// high and busy is low. Each item gives exactly one result, shown on the
// out_ ports for one cycle while out_valid is high; the receiver must take
// it then, as it cannot stall the block.
// Start, written bytes, read requests and stops that start no calculation
// answer in the cycle after the item is taken, and busy stays low.
// A stop that completes a packet with a known opcode runs the arithmetic
// unit and holds busy high until its result is shown: add, subtract and a
// zero divisor go straight to the done state, a multiply through its
// shift-add steps (one multiplier bit a cycle) and a divide through its
// restoring steps and, for a negative quotient, a negation step. The next
// item can be taken in the cycle that a result is shown.
// Reset clears the counts, the result word and the control state; the
// packet store needs no clearing, as a packet is only used once written.
module packet_alu_byte_slave_core #(
  parameter int OPERAND_BYTES = pab_pkg::OPERAND_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [7:0] in_wdata,
  output logic       out_valid,
  output logic [7:0] out_rdata,
  output logic       out_rdata_valid,
  output logic       out_computed
);

  localparam int W   = 8 * OPERAND_BYTES;
  localparam int PL  = 2 * OPERAND_BYTES + pab_pkg::OPCODE_BYTES;
  localparam int RCW = $clog2(PL + 1);
  localparam int IW  = $clog2(PL);
  localparam int RB  = pab_pkg::RESULT_BITS;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_CALC = 2'b10
  } tstate_t;

  tstate_t             state_r;
  logic [7:0]          pkt_r [PL];
  logic [RCW-1:0]      rx_cnt_r;
  logic [1:0]          tx_cnt_r;
  logic [RB-1:0]       res_word_r;
  logic                out_valid_r;
  logic [7:0]          out_rdata_r;
  logic                out_rdata_valid_r;
  logic                out_computed_r;

  logic                accept;
  logic                full;
  logic                known;
  logic [RCW-1:0]      wr_idx;
  logic [W-1:0]        opa_w;
  logic [W-1:0]        opb_w;
  logic [31:0]         opcode;
  pab_pkg::arith_req_t req;
  pab_pkg::arith_rsp_t rsp;

  always_comb begin
    for (int i = 0; i < OPERAND_BYTES; i++) begin
      opa_w[8*i +: 8] = pkt_r[i];
      opb_w[8*i +: 8] = pkt_r[OPERAND_BYTES + i];
    end
    for (int i = 0; i < pab_pkg::OPCODE_BYTES; i++) begin
      opcode[8*i +: 8] = pkt_r[2*OPERAND_BYTES + i];
    end
  end

  assign busy   = (state_r == T_CALC);
  assign accept = start && !busy;
  assign full   = (rx_cnt_r == RCW'(PL));
  assign known  = (opcode == pab_pkg::OPC_ADD) || (opcode == pab_pkg::OPC_MUL) ||
                  (opcode == pab_pkg::OPC_DIV) || (opcode == pab_pkg::OPC_SUB);
  assign wr_idx = full ? '0 : rx_cnt_r;

  assign req.start = accept && (in_func == pab_pkg::FUNC_STOP) && full && known;
  assign req.kind  = pab_pkg::kind_t'(opcode[1:0]);

  pab_arith #(
    .OPERAND_BYTES(OPERAND_BYTES)
  ) u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .op_a (opa_w),
    .op_b (opb_w),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (accept && (in_func == pab_pkg::FUNC_WRITE)) begin
      pkt_r[wr_idx[IW-1:0]] <= in_wdata;
    end
  end

  always_ff @(posedge clk) begin
    out_rdata_r       <= '0;
    out_rdata_valid_r <= 1'b0;
    out_computed_r    <= 1'b0;
    if (!rst_n) begin
      state_r     <= T_IDLE;
      rx_cnt_r    <= '0;
      tx_cnt_r    <= '0;
      res_word_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            unique case (in_func)
              pab_pkg::FUNC_START: begin
                rx_cnt_r    <= '0;
                tx_cnt_r    <= '0;
                out_valid_r <= 1'b1;
              end
              pab_pkg::FUNC_STOP: begin
                if (full && known) begin
                  state_r <= T_CALC;
                end else begin
                  out_valid_r <= 1'b1;
                  if (full) begin
                    res_word_r     <= '0;
                    out_computed_r <= 1'b1;
                  end
                end
              end
              pab_pkg::FUNC_WRITE: begin
                rx_cnt_r    <= wr_idx + RCW'(1);
                out_valid_r <= 1'b1;
              end
              pab_pkg::FUNC_READ: begin
                out_rdata_r       <= res_word_r[8*tx_cnt_r +: 8];
                out_rdata_valid_r <= 1'b1;
                tx_cnt_r          <= tx_cnt_r + 2'd1;
                out_valid_r       <= 1'b1;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        T_CALC: begin
          if (rsp.done) begin
            res_word_r     <= rsp.result;
            out_computed_r <= 1'b1;
            out_valid_r    <= 1'b1;
            state_r        <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rdata       = out_rdata_r;
  assign out_rdata_valid = out_rdata_valid_r;
  assign out_computed    = out_computed_r;

endmodule

// ===== test/packet_alu_byte_slave_core_check.sv =====
// Checker for the packet ALU byte slave: watches the event and result ports,
// predicts every result of each accepted item and compares them in order.
// Depends on pab_pkg for the event codes, opcodes and operand size.
module packet_alu_byte_slave_core_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_func,
  input  logic [7:0] in_wdata,
  input  logic       out_valid,
  input  logic [7:0] out_rdata,
  input  logic       out_rdata_valid,
  input  logic       out_computed,
  output int         errors,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import pab_pkg::*;

  localparam int OPND_BYTES = OPERAND_BYTES_DEF;
  localparam int PKT_LEN    = 2 * OPND_BYTES + OPCODE_BYTES;

  typedef struct packed {
    logic [7:0] rdata;
    logic       rdata_valid;
    logic       computed;
  } reply_t;

  logic [7:0]  pkt_store [PKT_LEN];
  int unsigned rx_cnt;
  logic [1:0]  tx_cnt;
  logic [31:0] result_q;
  reply_t      awaited [$];
  int          fails = 0;

  function automatic logic [63:0] sign_extend(input logic [63:0] v);
    logic [63:0] field;
    field = (64'd2 << (8 * OPND_BYTES - 1)) - 64'd1;
    v &= field;
    if (v[8 * OPND_BYTES - 1]) v |= ~field;
    return v;
  endfunction

  function automatic logic [31:0] alu_result();
    logic [63:0] a, b, ma, mb, q, r;
    logic [31:0] opc;
    a = '0;
    b = '0;
    opc = '0;
    for (int i = 0; i < OPND_BYTES && i < 8; i++) begin
      a[8 * i +: 8] = pkt_store[i];
      b[8 * i +: 8] = pkt_store[OPND_BYTES + i];
    end
    for (int i = 0; i < OPCODE_BYTES; i++) opc[8 * i +: 8] = pkt_store[2 * OPND_BYTES + i];
    a = sign_extend(a);
    b = sign_extend(b);
    case (opc)
      OPC_ADD: r = a + b;
      OPC_MUL: r = a * b;
      OPC_DIV: begin
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        if (mb == 64'd0) begin
          r = '0;
        end else begin
          q = ma / mb;
          r = (a[63] != b[63]) ? -q : q;
        end
      end
      OPC_SUB: r = a - b;
      default: r = '0;
    endcase
    return r[31:0];
  endfunction

  function automatic reply_t apply_event(input logic [1:0] func, input logic [7:0] data);
    reply_t r;
    r = '0;
    case (func)
      FUNC_START: begin
        rx_cnt = 0;
        tx_cnt = '0;
      end
      FUNC_STOP: begin
        if (rx_cnt == PKT_LEN) begin
          result_q = alu_result();
          r.computed = 1'b1;
        end
      end
      FUNC_WRITE: begin
        if (rx_cnt >= PKT_LEN) rx_cnt = 0;
        pkt_store[rx_cnt] = data;
        rx_cnt++;
      end
      default: begin
        r.rdata = result_q[8 * tx_cnt +: 8];
        r.rdata_valid = 1'b1;
        tx_cnt = tx_cnt + 2'd1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    reply_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < PKT_LEN; i++) pkt_store[i] = '0;
      rx_cnt = 0;
      tx_cnt = '0;
      result_q = '0;
      awaited.delete();
    end else begin
      if (out_valid) begin
        got = '{rdata: out_rdata, rdata_valid: out_rdata_valid, computed: out_computed};
        if (awaited.size() == 0) begin
          $error("result with no item waiting: rdata %0h", out_rdata);
          fails++;
        end else begin
          want = awaited.pop_front();
          if (got.rdata !== want.rdata) begin
            $error("out_rdata: expected %0h, got %0h", want.rdata, got.rdata);
            fails++;
          end
          if (got.rdata_valid !== want.rdata_valid) begin
            $error("out_rdata_valid: expected %0b, got %0b", want.rdata_valid,
                   got.rdata_valid);
            fails++;
          end
          if (got.computed !== want.computed) begin
            $error("out_computed: expected %0b, got %0b", want.computed, got.computed);
            fails++;
          end
        end
      end
      if (start && !busy) awaited.push_back(apply_event(in_func, in_wdata));
    end
    errors <= fails;
    outstanding <= awaited.size();
  end

endmodule

// ===== test/packet_alu_byte_slave_core_test.sv =====
// Testbench top for the packet ALU byte slave: drives directed and random bus
// events into the block and gives the verdict from the checker's count.
// Depends on pab_pkg, packet_alu_byte_slave_core and its checker module.
module packet_alu_byte_slave_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pab_pkg::*;

  localparam int OPND_BYTES = OPERAND_BYTES_DEF;
  localparam int PKT_LEN    = 2 * OPND_BYTES + OPCODE_BYTES;
  localparam int RANDOM_ITEMS = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [1:0] in_func = FUNC_START;
  logic [7:0] in_wdata = 8'h00;
  logic       busy;
  logic       out_valid;
  logic [7:0] out_rdata;
  logic       out_rdata_valid;
  logic       out_computed;
  int         errors;
  int         outstanding;
  int         sent = 0;
  int         idle_pct = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  packet_alu_byte_slave_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_wdata       (in_wdata),
    .out_valid      (out_valid),
    .out_rdata      (out_rdata),
    .out_rdata_valid(out_rdata_valid),
    .out_computed   (out_computed)
  );

  packet_alu_byte_slave_core_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_wdata       (in_wdata),
    .out_valid      (out_valid),
    .out_rdata      (out_rdata),
    .out_rdata_valid(out_rdata_valid),
    .out_computed   (out_computed),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  task automatic send_event(input logic [1:0] func, input logic [7:0] data);
    start <= 1'b1;
    in_func <= func;
    in_wdata <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    while (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [63:0] a, input logic [63:0] b,
                            input logic [31:0] opc, input int count);
    logic [7:0] img [PKT_LEN];
    for (int i = 0; i < OPND_BYTES; i++) begin
      img[i] = a[8 * i +: 8];
      img[OPND_BYTES + i] = b[8 * i +: 8];
    end
    for (int i = 0; i < OPCODE_BYTES; i++) img[2 * OPND_BYTES + i] = opc[8 * i +: 8];
    for (int i = 0; i < count; i++) begin
      if (i < PKT_LEN) send_event(FUNC_WRITE, img[i]);
      else send_event(FUNC_WRITE, 8'($urandom));
    end
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 64'd1;
      2: v = '1;
      3: v = {1'b0, {63{1'b1}}} >> (64 - 8 * OPND_BYTES);
      4: v = 64'd1 << (8 * OPND_BYTES - 1);
      5: v = 64'($urandom_range(0, 255));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_opcode();
    logic [31:0] opc;
    case ($urandom_range(0, 11))
      0, 1:    opc = OPC_ADD;
      2, 3, 4: opc = OPC_MUL;
      5, 6, 7: opc = OPC_DIV;
      8, 9:    opc = OPC_SUB;
      10:      opc = 32'($urandom_range(4, 255));
      default: opc = $urandom | (32'd1 << $urandom_range(2, 31));
    endcase
    return opc;
  endfunction

  task automatic run_sequence();
    logic [63:0] a, b;
    logic [31:0] opc;
    int count;
    a = pick_operand();
    b = pick_operand();
    opc = pick_opcode();
    if (opc == OPC_DIV && $urandom_range(0, 5) == 0) begin
      a = 64'd1 << (8 * OPND_BYTES - 1);
      b = '1;
    end else if (opc == OPC_DIV && $urandom_range(0, 5) == 0) begin
      b = '0;
    end
    case ($urandom_range(0, 9))
      0:       count = $urandom_range(0, PKT_LEN - 1);
      1:       count = $urandom_range(PKT_LEN + 1, 2 * PKT_LEN);
      default: count = PKT_LEN;
    endcase
    if ($urandom_range(0, 7) != 0) send_event(FUNC_START, 8'($urandom));
    send_bytes(a, b, opc, count);
    if ($urandom_range(0, 9) != 0) send_event(FUNC_STOP, 8'($urandom));
    repeat ($urandom_range(0, 6)) send_event(FUNC_READ, 8'($urandom));
    if ($urandom_range(0, 4) == 0) send_event(2'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 19;

    // Reset state, a stop with nothing received, then the most negative
    // dividend over minus one and reads that run past the result's end.
    send_event(FUNC_READ, 8'hFF);
    send_event(FUNC_STOP, 8'h00);
    send_event(FUNC_START, 8'hA5);
    send_bytes(64'd1 << (8 * OPND_BYTES - 1), '1, OPC_DIV, PKT_LEN);
    send_event(FUNC_STOP, 8'h5A);
    repeat (5) send_event(FUNC_READ, 8'h00);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) idle_pct = 19;
      else if (sent < 2 * RANDOM_ITEMS / 3) idle_pct = 50;
      else idle_pct = 0;
      run_sequence();
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("packet_alu_byte_slave_core_test OK");
    end else begin
      $display("packet_alu_byte_slave_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("packet_alu_byte_slave_core_test NOT OK");
    $finish;
  end

endmodule
